/* rtl/core/pfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

	// Default sizes of the pool.
	localparam int POOL_FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF   = 32;
	localparam int PIN_BITS_DEF    = 8;

	// Fixed widths of the request and result fields.
	localparam int OP_W     = 3;
	localparam int STATUS_W = 3;
	localparam int FIDX_W   = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_FETCH  = 3'd0,
		OP_NEW    = 3'd1,
		OP_UNPIN  = 3'd2,
		OP_FLUSH  = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_INVALID     = 3'd1,
		ST_NOT_RES     = 3'd2,
		ST_NO_FRAME    = 3'd3,
		ST_PINNED      = 3'd4,
		ST_NOT_PINNED  = 3'd5,
		ST_PIN_OVF     = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FSCAN,
		S_OSCAN,
		S_VREAD,
		S_VWAIT,
		S_SHIFT,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RO_NONE,
		RO_HEAD,
		RO_TAIL
	} reorder_t;

endpackage

`default_nettype wire

/* rtl/core/pfp_frame_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

// Frame table: page number, pin count and dirty mark per frame.
// Entries never written read as an empty, clean, unpinned frame.
module pfp_frame_mem import pfp_pkg::*; #(
	parameter int POOL_FRAMES = POOL_FRAMES_DEF,
	parameter int PAGE_BITS   = PAGE_BITS_DEF,
	parameter int PIN_BITS    = PIN_BITS_DEF,
	parameter int IW          = $clog2(POOL_FRAMES)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [IW-1:0]        wr_addr,
	input  wire logic [PAGE_BITS-1:0] wr_page,
	input  wire logic [PIN_BITS-1:0]  wr_pin,
	input  wire logic                 wr_dirty,
	input  wire logic [IW-1:0]        rd_addr,
	output logic      [PAGE_BITS-1:0] rd_page,
	output logic      [PIN_BITS-1:0]  rd_pin,
	output logic                      rd_dirty
);

	logic [PAGE_BITS-1:0] page_mem  [POOL_FRAMES];
	logic [PIN_BITS-1:0]  pin_mem   [POOL_FRAMES];
	logic                 dirty_mem [POOL_FRAMES];
	logic [POOL_FRAMES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			page_mem[wr_addr]  <= wr_page;
			pin_mem[wr_addr]   <= wr_pin;
			dirty_mem[wr_addr] <= wr_dirty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_q[rd_addr]) begin
			rd_page  <= page_mem[rd_addr];
			rd_pin   <= pin_mem[rd_addr];
			rd_dirty <= dirty_mem[rd_addr];
		end else begin
			rd_page  <= '1;
			rd_pin   <= '0;
			rd_dirty <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pfp_order_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

// Recency list: position 0 is the most recent frame. A position never
// written holds the frame of the same number.
module pfp_order_mem import pfp_pkg::*; #(
	parameter int POOL_FRAMES = POOL_FRAMES_DEF,
	parameter int IW          = $clog2(POOL_FRAMES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [IW-1:0] wr_addr,
	input  wire logic [IW-1:0] wr_frame,
	input  wire logic [IW-1:0] rd_addr,
	output logic      [IW-1:0] rd_frame
);

	logic [IW-1:0]          order_mem [POOL_FRAMES];
	logic [POOL_FRAMES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			order_mem[wr_addr] <= wr_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_q[rd_addr]) begin
			rd_frame <= order_mem[rd_addr];
		end else begin
			rd_frame <= rd_addr;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/page_frame_pool_lru_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                   Carries
// --------  --------------------------  ---------------------------------------------
// request   start, busy                 op, page_number, mark_dirty
// result    done (one-cycle strobe)     status, frame_index, hit, load_request,
//                                       writeback_request, writeback_page,
//                                       init_request, release_request,
//                                       resident_count, dirty_count
// config    cfg_valid, cfg_ready        cfg_data (invalid page number)
//
// One request is processed at a time. A transaction walks the frame table,
// then walks the recency list from its tail, reads the victim frame and
// decides, shifts the recency list if the order of frames changes, and
// finishes. Both walks are needed since each of the two memories has a
// single read port. done is raised for one cycle when busy has dropped;
// the receiver cannot stall, so results are never held back. The reset is
// asynchronous; both memories come out of reset in their initial contents
// through per-entry valid bits, so no clearing pass is needed.
module page_frame_pool_lru_unit import pfp_pkg::*; #(
	parameter int POOL_FRAMES = POOL_FRAMES_DEF,
	parameter int PAGE_BITS   = PAGE_BITS_DEF,
	parameter int PIN_BITS    = PIN_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [PAGE_BITS-1:0] page_number,
	input  wire logic                 mark_dirty,
	output logic                      done,
	output logic [STATUS_W-1:0]       status,
	output logic [FIDX_W-1:0]         frame_index,
	output logic                      hit,
	output logic                      load_request,
	output logic                      writeback_request,
	output logic [PAGE_BITS-1:0]      writeback_page,
	output logic                      init_request,
	output logic                      release_request,
	output logic [COUNT_W-1:0]        resident_count,
	output logic [COUNT_W-1:0]        dirty_count,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [PAGE_BITS-1:0] cfg_data
);

	localparam int IW = $clog2(POOL_FRAMES);
	localparam int CW = $clog2(POOL_FRAMES + 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
	localparam logic [IW:0] SCAN_END = (IW + 1)'(POOL_FRAMES);
	localparam logic [IW-1:0] LAST_POS = IW'(POOL_FRAMES - 1);

	state_t state_q, state_d;

	// Request and configuration registers.
	logic [OP_W-1:0]      op_q;
	logic [PAGE_BITS-1:0] pg_q;
	logic                 md_q;
	logic                 bad_q;
	logic [PAGE_BITS-1:0] inv_q;

	// Walk control shared by the two scans.
	logic [IW:0]   cnt_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_addr_s1;
	logic          scan_issue;
	logic          scan_last;

	// Frame table scan results.
	logic                   m_found_q;
	logic [IW-1:0]          m_idx_q;
	logic [PIN_BITS-1:0]    m_pin_q;
	logic                   m_dirty_q;
	logic [PAGE_BITS-1:0]   m_page_q;
	logic [CW-1:0]          res_cnt_q;
	logic [CW-1:0]          dty_cnt_q;
	logic [POOL_FRAMES-1:0] zpin_q;

	// Recency list scan results.
	logic          v_found_q;
	logic [IW-1:0] v_pos_q;
	logic [IW-1:0] v_frame_q;
	logic [IW-1:0] m_pos_q;

	// List shift control.
	reorder_t      ro_q;
	logic [IW-1:0] ro_frame_q;
	logic [IW-1:0] sh_cnt_q;
	logic [IW-1:0] sh_addr_q;
	logic          pend_s1;
	logic [IW-1:0] pend_addr_s1;

	// Memory ports.
	logic                 fr_wr_en;
	logic [PAGE_BITS-1:0] fr_wr_page;
	logic [PIN_BITS-1:0]  fr_wr_pin;
	logic                 fr_wr_dirty;
	logic [IW-1:0]        fr_rd_addr;
	logic [PAGE_BITS-1:0] fr_rd_page;
	logic [PIN_BITS-1:0]  fr_rd_pin;
	logic                 fr_rd_dirty;
	logic                 or_wr_en;
	logic [IW-1:0]        or_wr_addr;
	logic [IW-1:0]        or_wr_frame;
	logic [IW-1:0]        or_rd_addr;
	logic [IW-1:0]        or_rd_frame;

	// Decision, formed while the victim frame's data is on the read port.
	status_t              d_status;
	logic [IW-1:0]        d_fidx;
	logic                 d_hit;
	logic                 d_load;
	logic                 d_wb;
	logic [PAGE_BITS-1:0] d_wbpage;
	logic                 d_init;
	logic                 d_rel;
	logic                 d_fw_en;
	logic [IW-1:0]        d_fw_addr;
	logic [PAGE_BITS-1:0] d_fw_page;
	logic [PIN_BITS-1:0]  d_fw_pin;
	logic                 d_fw_dirty;
	reorder_t             d_ro;
	logic [IW-1:0]        d_ro_frame;
	logic [IW-1:0]        d_ro_pos;
	logic                 d_res_inc;
	logic                 d_res_dec;
	logic                 d_dty_inc;
	logic                 d_dty_dec;

	// Result registers.
	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic [IW-1:0]        fidx_q;
	logic                 hit_q;
	logic                 load_q;
	logic                 wb_q;
	logic [PAGE_BITS-1:0] wbpage_q;
	logic                 init_q;
	logic                 rel_q;
	logic [CW-1:0]        res_out_q;
	logic [CW-1:0]        dty_out_q;

	logic [IW+FIDX_W-1:0]  fidx_ext;
	logic [CW+COUNT_W-1:0] res_ext;
	logic [CW+COUNT_W-1:0] dty_ext;

	pfp_frame_mem #(
		.POOL_FRAMES (POOL_FRAMES),
		.PAGE_BITS   (PAGE_BITS),
		.PIN_BITS    (PIN_BITS),
		.IW          (IW)
	) u_frame_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fr_wr_en),
		.wr_addr  (d_fw_addr),
		.wr_page  (fr_wr_page),
		.wr_pin   (fr_wr_pin),
		.wr_dirty (fr_wr_dirty),
		.rd_addr  (fr_rd_addr),
		.rd_page  (fr_rd_page),
		.rd_pin   (fr_rd_pin),
		.rd_dirty (fr_rd_dirty)
	);

	pfp_order_mem #(
		.POOL_FRAMES (POOL_FRAMES),
		.IW          (IW)
	) u_order_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (or_wr_en),
		.wr_addr  (or_wr_addr),
		.wr_frame (or_wr_frame),
		.rd_addr  (or_rd_addr),
		.rd_frame (or_rd_frame)
	);

	// The scans issue one read per cycle; the last entry is consumed in the
	// cycle after its read, which is also the cycle that leaves the scan.
	assign scan_issue = (state_q == S_FSCAN || state_q == S_OSCAN) && (cnt_q != SCAN_END);
	assign scan_last  = (cnt_q == SCAN_END) && rd_vld_s1;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_FSCAN;
				end
			end
			S_FSCAN: begin
				if (scan_last) begin
					state_d = S_OSCAN;
				end
			end
			S_OSCAN: begin
				if (scan_last) begin
					state_d = S_VREAD;
				end
			end
			S_VREAD: state_d = S_VWAIT;
			S_VWAIT: begin
				if (d_ro == RO_NONE) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (sh_cnt_q == '0 && !pend_s1) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory control per state.
	always_comb begin
		fr_rd_addr  = v_frame_q;
		fr_wr_en    = 1'b0;
		fr_wr_page  = d_fw_page;
		fr_wr_pin   = d_fw_pin;
		fr_wr_dirty = d_fw_dirty;
		or_rd_addr  = sh_addr_q;
		or_wr_en    = 1'b0;
		or_wr_addr  = '0;
		or_wr_frame = ro_frame_q;
		case (state_q)
			S_FSCAN: fr_rd_addr = cnt_q[IW-1:0];
			S_OSCAN: or_rd_addr = LAST_POS - cnt_q[IW-1:0];
			S_VWAIT: fr_wr_en = d_fw_en;
			S_SHIFT: begin
				if (pend_s1) begin
					or_wr_en    = 1'b1;
					or_wr_frame = or_rd_frame;
					if (ro_q == RO_HEAD) begin
						or_wr_addr = pend_addr_s1 + IW'(1);
					end else begin
						or_wr_addr = pend_addr_s1 - IW'(1);
					end
				end else if (sh_cnt_q == '0) begin
					or_wr_en = 1'b1;
					if (ro_q == RO_HEAD) begin
						or_wr_addr = '0;
					end else begin
						or_wr_addr = LAST_POS;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Decision over the scan results and the victim frame.
	always_comb begin
		d_status   = ST_OK;
		d_fidx     = '0;
		d_hit      = 1'b0;
		d_load     = 1'b0;
		d_wb       = 1'b0;
		d_wbpage   = '0;
		d_init     = 1'b0;
		d_rel      = 1'b0;
		d_fw_en    = 1'b0;
		d_fw_addr  = m_idx_q;
		d_fw_page  = m_page_q;
		d_fw_pin   = m_pin_q;
		d_fw_dirty = m_dirty_q;
		d_ro       = RO_NONE;
		d_ro_frame = m_idx_q;
		d_ro_pos   = m_pos_q;
		d_res_inc  = 1'b0;
		d_res_dec  = 1'b0;
		d_dty_inc  = 1'b0;
		d_dty_dec  = 1'b0;
		if (bad_q) begin
			d_status = ST_INVALID;
		end else begin
			case (op_q)
				OP_FETCH, OP_NEW: begin
					if (m_found_q) begin
						d_fidx = m_idx_q;
						d_hit  = 1'b1;
						if (op_q == OP_NEW) begin
							d_status = ST_INVALID;
						end else begin
							d_fw_en = 1'b1;
							d_ro    = RO_HEAD;
							if (m_pin_q == PIN_MAX) begin
								d_status = ST_PIN_OVF;
							end else begin
								d_fw_pin = m_pin_q + PIN_BITS'(1);
							end
						end
					end else if (!v_found_q) begin
						d_status = ST_NO_FRAME;
						d_rel    = (op_q == OP_NEW);
					end else begin
						d_fidx     = v_frame_q;
						d_fw_en    = 1'b1;
						d_fw_addr  = v_frame_q;
						d_fw_page  = pg_q;
						d_fw_pin   = PIN_BITS'(1);
						d_fw_dirty = (op_q == OP_NEW);
						d_load     = (op_q == OP_FETCH);
						d_init     = (op_q == OP_NEW);
						d_ro       = RO_HEAD;
						d_ro_frame = v_frame_q;
						d_ro_pos   = v_pos_q;
						d_res_inc  = (fr_rd_page == inv_q);
						d_dty_inc  = (op_q == OP_NEW) && !fr_rd_dirty;
						d_dty_dec  = (op_q == OP_FETCH) && fr_rd_dirty;
						if (fr_rd_dirty && fr_rd_page != inv_q) begin
							d_wb     = 1'b1;
							d_wbpage = fr_rd_page;
						end
					end
				end
				OP_UNPIN: begin
					if (!m_found_q) begin
						d_status = ST_NOT_RES;
					end else begin
						d_fidx = m_idx_q;
						d_hit  = 1'b1;
						if (m_pin_q == '0) begin
							d_status = ST_NOT_PINNED;
						end else begin
							d_fw_en    = 1'b1;
							d_fw_pin   = m_pin_q - PIN_BITS'(1);
							d_fw_dirty = m_dirty_q | md_q;
							d_dty_inc  = md_q && !m_dirty_q;
							if (m_pin_q == PIN_BITS'(1)) begin
								d_ro = RO_TAIL;
							end
						end
					end
				end
				OP_FLUSH: begin
					if (m_found_q) begin
						d_fidx = m_idx_q;
						d_hit  = 1'b1;
						if (m_dirty_q) begin
							d_wb       = 1'b1;
							d_wbpage   = m_page_q;
							d_fw_en    = 1'b1;
							d_fw_dirty = 1'b0;
							d_dty_dec  = 1'b1;
						end
					end
				end
				OP_DELETE: begin
					if (!m_found_q) begin
						d_rel = 1'b1;
					end else begin
						d_fidx = m_idx_q;
						d_hit  = 1'b1;
						if (m_pin_q != '0) begin
							d_status = ST_PINNED;
						end else begin
							d_fw_en    = 1'b1;
							d_fw_page  = inv_q;
							d_fw_dirty = 1'b0;
							d_ro       = RO_TAIL;
							d_rel      = 1'b1;
							d_res_dec  = 1'b1;
							d_dty_dec  = m_dirty_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			inv_q      <= '1;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			pend_s1    <= 1'b0;
			done_q     <= 1'b0;
			ro_q       <= RO_NONE;
			sh_cnt_q   <= '0;
		end else begin
			state_q   <= state_d;
			done_q    <= (state_q == S_FINISH);
			rd_vld_s1 <= scan_issue;
			if (cfg_valid && cfg_ready) begin
				inv_q <= cfg_data;
			end
			if (scan_last || state_q == S_IDLE) begin
				cnt_q <= '0;
			end else if (scan_issue) begin
				cnt_q <= cnt_q + (IW + 1)'(1);
			end
			if (state_q == S_VWAIT) begin
				ro_q <= d_ro;
				if (d_ro == RO_HEAD) begin
					sh_cnt_q <= d_ro_pos;
				end else begin
					sh_cnt_q <= LAST_POS - d_ro_pos;
				end
				pend_s1 <= 1'b0;
			end else if (state_q == S_SHIFT) begin
				pend_s1 <= (sh_cnt_q != '0);
				if (sh_cnt_q != '0) begin
					sh_cnt_q <= sh_cnt_q - IW'(1);
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_addr_s1 <= (state_q == S_FSCAN) ? cnt_q[IW-1:0] : LAST_POS - cnt_q[IW-1:0];
		if (state_q == S_IDLE && start) begin
			op_q      <= op;
			pg_q      <= page_number;
			md_q      <= mark_dirty;
			bad_q     <= (op <= OP_DELETE) && (page_number == inv_q);
			m_found_q <= 1'b0;
			v_found_q <= 1'b0;
			m_idx_q   <= '0;
			m_pos_q   <= '0;
			v_frame_q <= '0;
			res_cnt_q <= '0;
			dty_cnt_q <= '0;
		end
		if (state_q == S_FSCAN && rd_vld_s1) begin
			zpin_q[rd_addr_s1] <= (fr_rd_pin == '0);
			res_cnt_q <= res_cnt_q + CW'(fr_rd_page != inv_q);
			dty_cnt_q <= dty_cnt_q + CW'(fr_rd_dirty);
			if (!m_found_q && fr_rd_page != inv_q && fr_rd_page == pg_q) begin
				m_found_q <= 1'b1;
				m_idx_q   <= rd_addr_s1;
				m_pin_q   <= fr_rd_pin;
				m_dirty_q <= fr_rd_dirty;
				m_page_q  <= fr_rd_page;
			end
		end
		// The recency walk runs from the tail, so the first unpinned frame
		// seen is the least recently used one.
		if (state_q == S_OSCAN && rd_vld_s1) begin
			if (!v_found_q && zpin_q[or_rd_frame]) begin
				v_found_q <= 1'b1;
				v_pos_q   <= rd_addr_s1;
				v_frame_q <= or_rd_frame;
			end
			if (m_found_q && or_rd_frame == m_idx_q) begin
				m_pos_q <= rd_addr_s1;
			end
		end
		if (state_q == S_VWAIT) begin
			status_q   <= d_status;
			fidx_q     <= d_fidx;
			hit_q      <= d_hit;
			load_q     <= d_load;
			wb_q       <= d_wb;
			wbpage_q   <= d_wbpage;
			init_q     <= d_init;
			rel_q      <= d_rel;
			res_out_q  <= res_cnt_q + CW'(d_res_inc) - CW'(d_res_dec);
			dty_out_q  <= dty_cnt_q + CW'(d_dty_inc) - CW'(d_dty_dec);
			ro_frame_q <= d_ro_frame;
			if (d_ro == RO_HEAD) begin
				sh_addr_q <= d_ro_pos - IW'(1);
			end else begin
				sh_addr_q <= d_ro_pos + IW'(1);
			end
		end else if (state_q == S_SHIFT && sh_cnt_q != '0) begin
			if (ro_q == RO_HEAD) begin
				sh_addr_q <= sh_addr_q - IW'(1);
			end else begin
				sh_addr_q <= sh_addr_q + IW'(1);
			end
		end
		pend_addr_s1 <= sh_addr_q;
	end

	assign fidx_ext = {{FIDX_W{1'b0}}, fidx_q};
	assign res_ext  = {{COUNT_W{1'b0}}, res_out_q};
	assign dty_ext  = {{COUNT_W{1'b0}}, dty_out_q};

	assign busy              = (state_q != S_IDLE);
	// A register write never lands in the same cycle as an accepted request,
	// so every request sees one consistent invalid page number.
	assign cfg_ready         = (state_q == S_IDLE) && !start;
	assign done              = done_q;
	assign status            = status_q;
	assign frame_index       = fidx_ext[FIDX_W-1:0];
	assign hit               = hit_q;
	assign load_request      = load_q;
	assign writeback_request = wb_q;
	assign writeback_page    = wbpage_q;
	assign init_request      = init_q;
	assign release_request   = rel_q;
	assign resident_count    = res_ext[COUNT_W-1:0];
	assign dirty_count       = dty_ext[COUNT_W-1:0];

	// A result is only presented once the block is free again.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// An accepted request always occupies the block in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted request did not start");

	// A hit never loads the page from backing store.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && (load_request || init_request)))
		else $error("hit with load or init request");

	// Writebacks only come from successful operations.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && writeback_request) |-> (status == ST_OK))
		else $error("writeback with failing status");

endmodule

`default_nettype wire
